// File: rtl/sac_pkg.sv
// Shared types and codes for the set-associative cache lookup.
`default_nettype none
package sac_pkg;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [31:0] tag;
        logic [31:0] rec;
        logic [31:0] arr;
        logic [31:0] cnt;
    } line_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETMOD,
        ST_SCAN,
        ST_DECIDE,
        ST_RANDMOD,
        ST_FETCH,
        ST_UPDATE
    } state_t;

    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;
    localparam logic [1:0] POL_LFU  = 2'd2;
    localparam logic [1:0] POL_RAND = 2'd3;

    localparam logic [1:0] KIND_HIT   = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_EVICT = 2'd2;

    localparam logic [2:0] REG_SET_BITS    = 3'd0;
    localparam logic [2:0] REG_OFFSET_BITS = 3'd1;
    localparam logic [2:0] REG_WAYS        = 3'd2;
    localparam logic [2:0] REG_POLICY      = 3'd3;
    localparam logic [2:0] REG_WRITE_BACK  = 3'd4;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

endpackage
`default_nettype wire

// File: rtl/set_assoc_cache_lookup.sv
// Top level: set-associative cache lookup with LRU, FIFO, LFU or random replacement.
// Sequence after accept: set wrap (no step when SETS >= 64), scan of the ways, decide,
//   a bit-serial mod over the 16 LFSR bits on a random victim, fetch, then update.
// Flow: one item in flight; the next is taken in idle after update; a stalled result holds update.
// Reset: after rst_n rises a clearing pass writes SETS*WAYS lines, one a cycle,
//   before the first item is taken. Config writes are taken at any time.
`default_nettype none
module set_assoc_cache_lookup #(
    parameter int SETS = 64,
    parameter int WAYS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] address
    input  wire logic [0:0]  s_tuser,   // [0] req_type
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [2:0] way_used, [8:3] set_index,
                                        // [9] mem_read, [10] mem_write, rest zero
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);

    localparam int DEPTH = SETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCW   = $clog2(WAYS + 1);
    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;

    // configuration
    logic [2:0] set_bits_reg;
    logic [3:0] offset_bits_reg;
    logic [3:0] ways_reg;
    logic [1:0] policy_reg;
    logic       wb_reg;

    // sequencer and datapath
    sac_pkg::state_t state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           store_reg, store_next;
    logic [31:0]    tag_reg, tag_next;
    logic [5:0]     set_reg, set_next;
    logic [WCW-1:0] issue_reg, issue_next;
    logic           ev_vld_reg, ev_vld_next;
    logic [WW-1:0]  ev_way_reg, ev_way_next;
    logic           hit_reg, hit_next;
    logic [WW-1:0]  hit_way_reg, hit_way_next;
    logic           free_reg, free_next;
    logic [WW-1:0]  free_way_reg, free_way_next;
    logic [31:0]    best_key_reg, best_key_next;
    logic [WW-1:0]  best_way_reg, best_way_next;
    logic [WW-1:0]  fin_way_reg, fin_way_next;
    logic [1:0]     kind_reg, kind_next;
    logic [4:0]     rem_reg, rem_next;
    logic [3:0]     bit_reg, bit_next;
    logic [31:0]    stamp_reg, stamp_next;
    logic [15:0]    lfsr_reg, lfsr_next;
    logic           m_valid_reg, m_valid_next;
    logic [15:0]    m_data_reg, m_data_next;
    logic [1:0]     m_user_reg, m_user_next;

    // line store ports
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    sac_pkg::line_t ram_wdata, ram_rdata;

    // effective configuration
    logic [2:0]     sb;
    logic [3:0]     ob;
    logic [WCW-1:0] aw;
    logic           out_free;
    logic           scan_last;
    logic           set_wrap;
    logic [31:0]    scan_key;
    logic [15:0]    lfsr_step;
    logic [5:0]     rem_try;

    assign sb = (set_bits_reg > 3'd6) ? 3'd6 : set_bits_reg;
    assign ob = (offset_bits_reg > 4'd12) ? 4'd12 : offset_bits_reg;
    always_comb
    begin
        if (ways_reg == 4'd0)
        begin
            aw = WCW'(1);
        end
        else if (32'(ways_reg) > WAYS)
        begin
            aw = WCW'(WAYS);
        end
        else
        begin
            aw = WCW'(ways_reg);
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign scan_last = ev_vld_reg && (32'(ev_way_reg) == 32'(aw) - 1);
    assign set_wrap  = 32'(set_reg) >= SETS;
    assign cfg_ready = 1'b1;

    // key of the active policy for the way being scanned
    always_comb
    begin
        case (policy_reg)
            sac_pkg::POL_FIFO: scan_key = ram_rdata.arr;
            sac_pkg::POL_LFU:  scan_key = ram_rdata.cnt;
            default:           scan_key = ram_rdata.rec;
        endcase
    end

    // one Galois step, zero reloads the seed
    always_comb
    begin
        logic [15:0] v;
        v = (lfsr_reg == 16'd0) ? sac_pkg::LFSR_SEED : lfsr_reg;
        lfsr_step = v[0] ? ((v >> 1) ^ sac_pkg::LFSR_TAPS) : (v >> 1);
    end

    // one restoring step of lfsr mod ways
    always_comb
    begin
        logic [5:0] t;
        t = {rem_reg, lfsr_reg[bit_reg]};
        rem_try = (t >= 6'(aw)) ? (t - 6'(aw)) : t;
    end

    function automatic logic [AW-1:0] line_addr(input logic [5:0] s, input logic [WW-1:0] w);
        logic [SW-1:0] si;
        si = SW'(s);
        return AW'(si) * AW'(WAYS) + AW'(w);
    endfunction

    sac_line_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sac_pkg::ST_CLEAR:
                if (clr_reg == AW'(DEPTH - 1)) state_next = sac_pkg::ST_IDLE;
            sac_pkg::ST_IDLE:
                if (s_tvalid) state_next = sac_pkg::ST_SETMOD;
            sac_pkg::ST_SETMOD:
                if (!set_wrap) state_next = sac_pkg::ST_SCAN;
            sac_pkg::ST_SCAN:
                if (scan_last) state_next = sac_pkg::ST_DECIDE;
            sac_pkg::ST_DECIDE:
                if (!hit_reg && !free_reg && policy_reg == sac_pkg::POL_RAND)
                    state_next = sac_pkg::ST_RANDMOD;
                else
                    state_next = sac_pkg::ST_FETCH;
            sac_pkg::ST_RANDMOD:
                if (bit_reg == 4'd0) state_next = sac_pkg::ST_FETCH;
            sac_pkg::ST_FETCH:
                state_next = sac_pkg::ST_UPDATE;
            sac_pkg::ST_UPDATE:
                if (out_free) state_next = sac_pkg::ST_IDLE;
            default:
                state_next = sac_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sac_pkg::line_t e;
        logic           mw;
        logic [31:0]    addr_sh;

        clr_next      = clr_reg;
        store_next    = store_reg;
        tag_next      = tag_reg;
        set_next      = set_reg;
        issue_next    = issue_reg;
        ev_vld_next   = 1'b0;
        ev_way_next   = ev_way_reg;
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        free_next     = free_reg;
        free_way_next = free_way_reg;
        best_key_next = best_key_reg;
        best_way_next = best_way_reg;
        fin_way_next  = fin_way_reg;
        kind_next     = kind_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        stamp_next    = stamp_reg;
        lfsr_next     = lfsr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        ram_we        = 1'b0;
        ram_waddr     = line_addr(set_reg, fin_way_reg);
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = line_addr(set_reg, fin_way_reg);
        s_tready      = 1'b0;
        e             = ram_rdata;
        mw            = 1'b0;
        addr_sh       = s_tdata >> ob;

        case (state_reg)
            sac_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            sac_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                store_next = s_tuser[0];
                tag_next   = s_tdata >> (6'(sb) + 6'(ob));
                set_next   = 6'(addr_sh & ((32'd1 << sb) - 32'd1));
                issue_next = '0;
                hit_next   = 1'b0;
                free_next  = 1'b0;
            end
            sac_pkg::ST_SETMOD:
                if (set_wrap) set_next = set_reg - 6'(SETS);
            sac_pkg::ST_SCAN:
            begin
                if (issue_reg < aw)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = line_addr(set_reg, issue_reg[WW-1:0]);
                    issue_next  = issue_reg + WCW'(1);
                    ev_vld_next = 1'b1;
                    ev_way_next = issue_reg[WW-1:0];
                end
                if (ev_vld_reg)
                begin
                    if (!hit_reg && ram_rdata.valid && ram_rdata.tag == tag_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_way_next = ev_way_reg;
                    end
                    if (!free_reg && !ram_rdata.valid)
                    begin
                        free_next     = 1'b1;
                        free_way_next = ev_way_reg;
                    end
                    if (ev_way_reg == '0 || scan_key < best_key_reg)
                    begin
                        best_key_next = scan_key;
                        best_way_next = ev_way_reg;
                    end
                end
            end
            sac_pkg::ST_DECIDE:
            begin
                if (hit_reg)
                begin
                    kind_next    = sac_pkg::KIND_HIT;
                    fin_way_next = hit_way_reg;
                end
                else if (free_reg)
                begin
                    kind_next    = sac_pkg::KIND_FREE;
                    fin_way_next = free_way_reg;
                end
                else
                begin
                    kind_next    = sac_pkg::KIND_EVICT;
                    fin_way_next = best_way_reg;
                    if (policy_reg == sac_pkg::POL_RAND)
                    begin
                        lfsr_next = lfsr_step;
                        rem_next  = '0;
                        bit_next  = 4'd15;
                    end
                end
            end
            sac_pkg::ST_RANDMOD:
            begin
                rem_next = rem_try[4:0];
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0) fin_way_next = WW'(rem_try);
            end
            sac_pkg::ST_FETCH:
                ram_re = 1'b1;
            sac_pkg::ST_UPDATE:
            begin
                if (kind_reg == sac_pkg::KIND_HIT)
                begin
                    if (store_reg)
                    begin
                        if (wb_reg) e.dirty = 1'b1;
                        else mw = 1'b1;
                    end
                    if (policy_reg == sac_pkg::POL_LRU)
                    begin
                        e.rec      = stamp_reg;
                        stamp_next = stamp_reg + 32'd1;
                    end
                    else if (policy_reg == sac_pkg::POL_LFU && e.cnt != 32'hFFFF_FFFF)
                    begin
                        e.cnt = e.cnt + 32'd1;
                    end
                end
                else
                begin
                    // dirty victim goes back to memory under write-back
                    mw      = (kind_reg == sac_pkg::KIND_EVICT) && wb_reg && ram_rdata.valid
                              && ram_rdata.dirty;
                    e.valid = 1'b1;
                    e.tag   = tag_reg;
                    e.dirty = 1'b0;
                    case (policy_reg)
                        sac_pkg::POL_LRU:
                        begin
                            e.rec      = stamp_reg;
                            stamp_next = stamp_reg + 32'd1;
                        end
                        sac_pkg::POL_FIFO:
                        begin
                            e.arr      = stamp_reg;
                            stamp_next = stamp_reg + 32'd1;
                        end
                        sac_pkg::POL_LFU:
                            e.cnt = 32'd1;
                        default:
                            e.cnt = ram_rdata.cnt;
                    endcase
                    if (store_reg)
                    begin
                        if (wb_reg) e.dirty = 1'b1;
                        else mw = 1'b1;
                    end
                end
                if (out_free)
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = e;
                    m_valid_next = 1'b1;
                    m_user_next  = kind_reg;
                    m_data_next  = {5'd0, mw, (kind_reg != sac_pkg::KIND_HIT),
                                    set_reg, 3'(fin_way_reg)};
                end
                else
                begin
                    stamp_next = stamp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= 3'd6;
            offset_bits_reg <= 4'd6;
            ways_reg        <= 4'd8;
            policy_reg      <= sac_pkg::POL_LRU;
            wb_reg          <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sac_pkg::REG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                sac_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                sac_pkg::REG_WAYS:        ways_reg        <= cfg_data;
                sac_pkg::REG_POLICY:      policy_reg      <= cfg_data[1:0];
                sac_pkg::REG_WRITE_BACK:  wb_reg          <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sac_pkg::ST_CLEAR;
            clr_reg     <= '0;
            issue_reg   <= '0;
            ev_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            bit_reg     <= '0;
            stamp_reg   <= '0;
            lfsr_reg    <= sac_pkg::LFSR_SEED;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            issue_reg   <= issue_next;
            ev_vld_reg  <= ev_vld_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            bit_reg     <= bit_next;
            stamp_reg   <= stamp_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg    <= store_next;
        tag_reg      <= tag_next;
        set_reg      <= set_next;
        ev_way_reg   <= ev_way_next;
        hit_way_reg  <= hit_way_next;
        free_way_reg <= free_way_next;
        best_key_reg <= best_key_next;
        best_way_reg <= best_way_next;
        fin_way_reg  <= fin_way_next;
        kind_reg     <= kind_next;
        rem_reg      <= rem_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // one item in flight: no second accept right after one
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a fetch is reported exactly on a miss
    a_read_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == sac_pkg::KIND_HIT) == !m_tdata[9]))
        else $error("mem_read does not match result kind");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined result kind");

    // the random source never locks up at zero
    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 16'd0)
        else $error("lfsr reached zero");

endmodule
`default_nettype wire

// File: rtl/sac_line_ram.sv
// Line store: one cache line per entry, one write and one registered read port.
`default_nettype none
module sac_line_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire sac_pkg::line_t wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output sac_pkg::line_t     rdata
);

    sac_pkg::line_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the set-associative cache lookup.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS = 64;
    localparam int NWAYS = 8;
    localparam int RANDOM_ITEMS = 1530;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    // one lookup outcome, as carried on the result stream
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] way;
        logic [5:0] set;
        logic       rd;
        logic       wr;
    } outcome_t;

    // one directed row: access, and the outcome when it is typed in
    typedef struct {
        logic       store;
        logic [31:0] addr;
        logic       typed;   // expected value given below
        outcome_t   want;
    } row_t;

    set_assoc_cache_lookup #(.SETS(NSETS), .WAYS(NWAYS)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the cache
    logic        sh_valid [NSETS][NWAYS];
    logic        sh_dirty [NSETS][NWAYS];
    logic [31:0] sh_tag   [NSETS][NWAYS];
    logic [31:0] sh_rec   [NSETS][NWAYS];
    logic [31:0] sh_arr   [NSETS][NWAYS];
    logic [31:0] sh_cnt   [NSETS][NWAYS];
    logic [31:0] sh_stamp;
    logic [15:0] sh_lfsr;
    logic [2:0]  c_setb;
    logic [3:0]  c_offb;
    logic [3:0]  c_ways;
    logic [1:0]  c_pol;
    logic        c_wb;

    outcome_t pending_outcomes[$];
    int errors = 0;
    int items_sent = 0;
    bit quiet_mode = 1'b0;   // no idling near the end

    function automatic outcome_t cache_lookup(logic store, logic [31:0] addr);
        int sb, ob, ways, set, way;
        logic [31:0] tag;
        logic hit, found;
        outcome_t o;
        logic [31:0] best;
        sb = (c_setb > 6) ? 6 : c_setb;
        ob = (c_offb > 12) ? 12 : c_offb;
        ways = (c_ways < 1) ? 1 : ((c_ways > NWAYS) ? NWAYS : c_ways);
        tag = addr >> (sb + ob);
        set = ((addr >> ob) & ((32'd1 << sb) - 1)) % NSETS;
        o = '0;
        hit = 1'b0;
        way = 0;
        for (int i = 0; i < ways; i++)
            if (!hit && sh_valid[set][i] && sh_tag[set][i] == tag)
            begin
                hit = 1'b1;
                way = i;
            end
        if (hit)
        begin
            o.kind = sac_pkg::KIND_HIT;
            if (store)
            begin
                if (c_wb) sh_dirty[set][way] = 1'b1;
                else o.wr = 1'b1;
            end
            if (c_pol == sac_pkg::POL_LRU)
            begin
                sh_rec[set][way] = sh_stamp;
                sh_stamp++;
            end
            else if (c_pol == sac_pkg::POL_LFU && sh_cnt[set][way] != 32'hFFFF_FFFF)
                sh_cnt[set][way]++;
        end
        else
        begin
            o.rd = 1'b1;
            found = 1'b0;
            for (int i = 0; i < ways; i++)
                if (!found && !sh_valid[set][i])
                begin
                    found = 1'b1;
                    way = i;
                end
            if (found)
                o.kind = sac_pkg::KIND_FREE;
            else
            begin
                o.kind = sac_pkg::KIND_EVICT;
                if (c_pol == sac_pkg::POL_RAND)
                begin
                    if (sh_lfsr == 0) sh_lfsr = sac_pkg::LFSR_SEED;
                    sh_lfsr = sh_lfsr[0] ? ((sh_lfsr >> 1) ^ sac_pkg::LFSR_TAPS)
                                         : (sh_lfsr >> 1);
                    way = sh_lfsr % ways;
                end
                else
                begin
                    way = 0;
                    for (int i = 1; i < ways; i++)
                    begin
                        best = (c_pol == sac_pkg::POL_FIFO) ? sh_arr[set][way] :
                               (c_pol == sac_pkg::POL_LFU) ? sh_cnt[set][way] :
                               sh_rec[set][way];
                        if (((c_pol == sac_pkg::POL_FIFO) ? sh_arr[set][i] :
                             (c_pol == sac_pkg::POL_LFU) ? sh_cnt[set][i] :
                             sh_rec[set][i]) < best)
                            way = i;
                    end
                end
                if (c_wb && sh_dirty[set][way]) o.wr = 1'b1;
            end
            sh_valid[set][way] = 1'b1;
            sh_tag[set][way] = tag;
            sh_dirty[set][way] = 1'b0;
            if (c_pol == sac_pkg::POL_LRU)
            begin
                sh_rec[set][way] = sh_stamp;
                sh_stamp++;
            end
            else if (c_pol == sac_pkg::POL_FIFO)
            begin
                sh_arr[set][way] = sh_stamp;
                sh_stamp++;
            end
            else if (c_pol == sac_pkg::POL_LFU)
                sh_cnt[set][way] = 32'd1;
            if (store)
            begin
                if (c_wb) sh_dirty[set][way] = 1'b1;
                else o.wr = 1'b1;
            end
        end
        o.way = way[2:0];
        o.set = set[5:0];
        return o;
    endfunction

    // valid drops for one cycle after each write, so it is never driven twice in a step
    task automatic write_reg(logic [2:0] idx, logic [3:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sac_pkg::REG_SET_BITS:    c_setb = val[2:0];
            sac_pkg::REG_OFFSET_BITS: c_offb = val;
            sac_pkg::REG_WAYS:        c_ways = val;
            sac_pkg::REG_POLICY:      c_pol  = val[1:0];
            sac_pkg::REG_WRITE_BACK:  c_wb   = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // every result must have arrived and the block gone quiet
    task automatic drain;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // the block is busy after an accept until its update is done, so the one-cycle
    // valid drop afterwards costs no throughput
    task automatic send_access(logic store, logic [31:0] addr);
        int gap;
        if (!quiet_mode && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= addr;
        s_tuser  <= store;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        s_tvalid <= 1'b0;
        pending_outcomes.push_back(cache_lookup(store, addr));
        items_sent++;
        @(posedge clk);
    endtask

    // result side: random stall bursts, checks each item against the oldest expectation
    initial
    begin
        int stall;
        outcome_t want, got;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.way  = m_tdata[2:0];
                got.set  = m_tdata[8:3];
                got.rd   = m_tdata[9];
                got.wr   = m_tdata[10];
                if (pending_outcomes.size() == 0)
                begin
                    $error("result item with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.way !== want.way)
                    begin
                        $error("way_used: expected %0d, got %0d", want.way, got.way);
                        errors++;
                    end
                    if (got.set !== want.set)
                    begin
                        $error("set_index: expected %0d, got %0d", want.set, got.set);
                        errors++;
                    end
                    if (got.rd !== want.rd)
                    begin
                        $error("mem_read: expected %0d, got %0d", want.rd, got.rd);
                        errors++;
                    end
                    if (got.wr !== want.wr)
                    begin
                        $error("mem_write: expected %0d, got %0d", want.wr, got.wr);
                        errors++;
                    end
                end
            end
            if (!quiet_mode && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                // note: no acceptance possible while tready low, nothing missed
            end
            m_tready <= 1'b1;
        end
    end

    // address built from tag, set and offset under the current register values
    function automatic logic [31:0] make_addr(int tagv, int setv);
        int sb, ob;
        sb = (c_setb > 6) ? 6 : c_setb;
        ob = (c_offb > 12) ? 12 : c_offb;
        return (32'(tagv) << (sb + ob)) | ((32'(setv) & ((32'd1 << sb) - 1)) << ob)
               | (($urandom) & ((32'd1 << ob) - 1));
    endfunction

    initial
    begin
        row_t rows[$];
        row_t r;
        int phase_len, hot_set, ntags;
        c_setb = 6; c_offb = 6; c_ways = 8; c_pol = sac_pkg::POL_LRU; c_wb = 1'b1;
        sh_stamp = '0;
        sh_lfsr = sac_pkg::LFSR_SEED;
        foreach (sh_valid[s, w])
        begin
            sh_valid[s][w] = 0; sh_dirty[s][w] = 0; sh_tag[s][w] = 0;
            sh_rec[s][w] = 0; sh_arr[s][w] = 0; sh_cnt[s][w] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings: first touches typed in
        rows.push_back('{1'b0, 32'h0000_0000, 1'b1,
                         '{sac_pkg::KIND_FREE, 3'd0, 6'd0, 1'b1, 1'b0}});
        rows.push_back('{1'b1, 32'h0000_0004, 1'b1,
                         '{sac_pkg::KIND_HIT, 3'd0, 6'd0, 1'b0, 1'b0}});
        rows.push_back('{1'b1, 32'hFFFF_FFFF, 1'b1,
                         '{sac_pkg::KIND_FREE, 3'd0, 6'd63, 1'b1, 1'b0}});
        rows.push_back('{1'b0, 32'h0000_1000, 1'b1,
                         '{sac_pkg::KIND_FREE, 3'd1, 6'd0, 1'b1, 1'b0}});
        // fill set 0 fully then evict; dirty line 0 goes out
        for (int t = 2; t < 10; t++)
            rows.push_back('{1'b0, 32'(t) << 12, 1'b0, '0});
        rows.push_back('{1'b0, 32'hAAAA_AAC0, 1'b0, '0});
        foreach (rows[i])
        begin
            r = rows[i];
            send_access(r.store, r.addr);
            if (r.typed && pending_outcomes[$] !== r.want)
            begin
                $error("directed row %0d: table %h, predictor %h", i, r.want,
                       pending_outcomes[$]);
                errors++;
            end
        end
        drain();

        // extremes of every register, plus out-of-range codes
        write_reg(sac_pkg::REG_SET_BITS, 4'd7);
        write_reg(sac_pkg::REG_OFFSET_BITS, 4'd15);
        write_reg(sac_pkg::REG_WAYS, 4'd0);
        write_reg(sac_pkg::REG_POLICY, 4'(sac_pkg::POL_RAND));
        write_reg(sac_pkg::REG_WRITE_BACK, 4'd0);
        for (int i = 0; i < 8; i++)
            send_access(i[0], {i[2:0], 29'h0} | 32'h0000_1000);
        drain();
        write_reg(sac_pkg::REG_SET_BITS, 4'd0);
        write_reg(sac_pkg::REG_OFFSET_BITS, 4'd0);
        write_reg(sac_pkg::REG_WAYS, 4'd15);
        write_reg(sac_pkg::REG_POLICY, 4'(sac_pkg::POL_FIFO));
        write_reg(sac_pkg::REG_WRITE_BACK, 4'd1);
        for (int i = 0; i < 4; i++)
            send_access(1'b1, 32'(i * 7));
        drain();

        // random phases: mostly reuse of a small tag pool to force hits and evictions
        for (int ph = 0; items_sent < RANDOM_ITEMS + 20; ph++)
        begin
            write_reg(sac_pkg::REG_SET_BITS, 4'($urandom_range(0, 7)));
            write_reg(sac_pkg::REG_OFFSET_BITS, 4'($urandom_range(0, 15)));
            write_reg(sac_pkg::REG_WAYS, 4'($urandom_range(0, 15)));
            write_reg(sac_pkg::REG_POLICY, 4'($urandom_range(0, 3)));
            write_reg(sac_pkg::REG_WRITE_BACK, 4'($urandom_range(0, 1)));
            phase_len = $urandom_range(60, 160);
            ntags = $urandom_range(2, 14);
            hot_set = $urandom_range(0, 63);
            for (int k = 0; k < phase_len && items_sent < RANDOM_ITEMS + 20; k++)
            begin
                if (items_sent > RANDOM_ITEMS - 150) quiet_mode = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    send_access(1'($urandom_range(0, 1)), $urandom);
                else
                    send_access(1'($urandom_range(0, 1)),
                                make_addr($urandom_range(0, ntags - 1) * 32'h1357 + ph,
                                          ($urandom_range(0, 3) == 0) ?
                                          $urandom_range(0, 63) : hot_set));
            end
            drain();
        end

        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
